// ===== design/load_cell_adc_reader_assert.svh =====
// assertion macros for the load cell adc reader
// expects clk and rst_n in the scope of each use; empty when SYNTH is defined
`ifndef LOAD_CELL_ADC_READER_ASSERT_SVH
`define LOAD_CELL_ADC_READER_ASSERT_SVH
`ifndef SYNTH
// consequent checked in the same cycle
`define LCAR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("load cell adc reader check failed");
// consequent checked in the next cycle
`define LCAR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("load cell adc reader check failed");
`else
`define LCAR_ASSERT_NOW(label, ante, cons)
`define LCAR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/lcar_pkg.sv =====
// types, codes and microcode table of the load cell adc reader
// no dependencies; used by load_cell_adc_reader
package lcar_pkg;

  // request codes carried in req_type
  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_MEASURE = 3'd1;
  localparam logic [2:0] REQ_TARE    = 3'd2;
  localparam logic [2:0] REQ_PDOWN   = 3'd3;
  localparam logic [2:0] REQ_PUP     = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd0;
  localparam logic [1:0] CFG_GAIN_Q32     = 2'd1;
  localparam logic [1:0] CFG_CLAMP_Q8     = 2'd2;

  // reset values
  localparam logic [7:0]  SAMPLE_COUNT_RST = 8'd10;
  localparam logic [31:0] GAIN_Q32_RST     = 32'd218530;
  localparam logic [22:0] CLAMP_Q8_RST     = 23'd128000;
  localparam logic [23:0] OFFSET_RST       = 24'd8533654;

  // weight arithmetic constants
  localparam logic [55:0] ROUND_HALF = 56'h80_0000;
  localparam logic [23:0] NEG_FLOOR  = 24'h80_0000;

  // payload of one input beat
  typedef struct packed {
    logic [2:0] req_type;
    logic       dout_level;
  } in_item_t;

  // payload of one result beat
  typedef struct packed {
    logic               sck_level;
    logic               busy_res;
    logic               measure_done;
    logic               tare_done;
    logic [23:0]        raw_average;
    logic signed [23:0] weight_q8;
  } out_item_t;

  // serial bus phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_WAIT   = 5'b00010,
    PH_HIGH   = 5'b00100,
    PH_SAMPLE = 5'b01000,
    PH_EXTRA  = 5'b10000
  } phase_t;

  // datapath operations of one microcode step
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_DIV,
    OP_AVG,
    OP_DIFF,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_SUM,
    OP_SCALE,
    OP_EMIT
  } uop_t;

  // jump conditions
  typedef enum logic [2:0] {
    JC_NONE,
    JC_ALWAYS,
    JC_NOT_FINISH,
    JC_DIV_MORE,
    JC_TARE
  } jcond_t;

  typedef logic [3:0] step_t;

  typedef struct packed {
    uop_t   op;
    jcond_t cond;
    step_t  target;
  } ucode_word_t;

  // program addresses
  localparam step_t STEP_ACCEPT = 4'd0;
  localparam step_t STEP_DIV    = 4'd1;
  localparam step_t STEP_AVG    = 4'd2;
  localparam step_t STEP_DIFF   = 4'd3;
  localparam step_t STEP_MUL_LO = 4'd4;
  localparam step_t STEP_MUL_HI = 4'd5;
  localparam step_t STEP_SUM    = 4'd6;
  localparam step_t STEP_SCALE  = 4'd7;
  localparam step_t STEP_EMIT   = 4'd8;

  // microcode program
  function automatic ucode_word_t ucode_rom(input step_t step);
    ucode_word_t w;
    case (step)
      STEP_ACCEPT: w = '{op: OP_ACCEPT, cond: JC_NOT_FINISH, target: STEP_EMIT};
      STEP_DIV:    w = '{op: OP_DIV,    cond: JC_DIV_MORE,   target: STEP_DIV};
      STEP_AVG:    w = '{op: OP_AVG,    cond: JC_TARE,       target: STEP_EMIT};
      STEP_DIFF:   w = '{op: OP_DIFF,   cond: JC_NONE,       target: STEP_ACCEPT};
      STEP_MUL_LO: w = '{op: OP_MUL_LO, cond: JC_NONE,       target: STEP_ACCEPT};
      STEP_MUL_HI: w = '{op: OP_MUL_HI, cond: JC_NONE,       target: STEP_ACCEPT};
      STEP_SUM:    w = '{op: OP_SUM,    cond: JC_NONE,       target: STEP_ACCEPT};
      STEP_SCALE:  w = '{op: OP_SCALE,  cond: JC_NONE,       target: STEP_ACCEPT};
      STEP_EMIT:   w = '{op: OP_EMIT,   cond: JC_ALWAYS,     target: STEP_ACCEPT};
      default:     w = '{op: OP_NOP,    cond: JC_ALWAYS,     target: STEP_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

// ===== design/load_cell_adc_reader.sv =====
// load cell adc reader: serial master, averaging, tare and weight scaling
// depends on lcar_pkg and load_cell_adc_reader_assert.svh
//
// Usage: every input beat is one serial half-period tick (req_type tick with
// the sampled data pin level) or a request: measure, tare, power down or
// power up. Every input beat gives exactly one result beat carrying the serial
// clock level to drive, the busy flag and, on the beat that ends a sequence,
// the averaged raw value with either the weight or the tare flag.
// Configuration (sample_count, gain_q32, clamp_limit_q8) is written through
// cfg_we / cfg_index / cfg_wdata; users write it between beats (not enforced).
// Sequencing: a microcoded sequencer runs each beat. An ordinary tick runs
// the accept and emit steps. The beat that ends a measure runs accept, a
// 32-step restoring divide of the sum by the conversion count (one quotient
// bit per cycle), the average step, then difference, two 24x16 partial
// products, the rounding add, the scale/clamp step and emit. The beat that
// ends a tare stops after the average step and goes on to emit.
// The next input beat is taken while a result still waits in the output
// register; if the receiver stalls, the sequencer holds at its emit step.
// Reset (synchronous, rst_n low) returns the control, configuration and bus
// registers to defaults, bus idle, no result pending; datapath regs are not reset.
`include "load_cell_adc_reader_assert.svh"

module load_cell_adc_reader #(
  parameter int DATA_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  lcar_pkg::in_item_t  in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output lcar_pkg::out_item_t out_data,
  // configuration
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import lcar_pkg::*;

  localparam logic [4:0]           DATA_BITS_C = 5'(DATA_BITS);
  localparam logic [DATA_BITS-1:0] TOP_BIT     = {1'b1, {(DATA_BITS - 1){1'b0}}};

  // configuration registers
  logic [7:0]  sample_count_r;
  logic [31:0] gain_r;
  logic [22:0] clamp_r;

  // serial bus state
  phase_t               phase_r, phase_nxt;
  logic [4:0]           bit_cnt_r, bit_cnt_nxt;
  logic [7:0]           smp_cnt_r, smp_cnt_nxt;
  logic [DATA_BITS-1:0] shift_r, shift_nxt;
  logic [31:0]          sum_r, sum_nxt;
  logic [23:0]          offset_r;
  logic                 tare_r, tare_nxt;
  logic                 pdown_r, pdown_nxt;

  // sequencer
  step_t       step_r, step_nxt;
  ucode_word_t ucw;
  logic        go;
  logic        take;

  // per-beat results of the bus logic
  logic        sck_c;
  logic        finish_c;
  logic [31:0] sum_add_c;
  logic [7:0]  smp_inc_c;
  logic [7:0]  limit_c;
  logic [8:0]  div_n_c;
  logic        handled_c;

  // divider
  logic [31:0] div_q_r;
  logic [8:0]  div_rem_r;
  logic [8:0]  div_d_r;
  logic [4:0]  div_cnt_r;
  logic [9:0]  rem_sh_c;
  logic        q_bit_c;
  logic [8:0]  rem_nxt_c;

  // weight datapath
  logic        neg_r;
  logic [23:0] mag_r;
  logic [39:0] pp_lo_r;
  logic [39:0] pp_hi_r;
  logic [55:0] prod_r;
  logic [24:0] diff_c;
  logic [31:0] q_c;
  logic [23:0] q_sat_c;

  // pending result fields
  logic        res_sck_r;
  logic        res_busy_r;
  logic        res_mdone_r;
  logic        res_tdone_r;
  logic [23:0] res_avg_r;
  logic [23:0] res_weight_r;

  // output register
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      emit_ok;
  logic      in_beat;

  // microcode fetch and step control
  assign ucw      = ucode_rom(step_r);
  assign emit_ok  = !out_valid_r || !out_stall;
  assign in_stall = (ucw.op != OP_ACCEPT);
  assign in_beat  = in_valid && !in_stall;

  always_comb begin
    case (ucw.op)
      OP_ACCEPT: go = in_valid;
      OP_EMIT:   go = emit_ok;
      default:   go = 1'b1;
    endcase
    case (ucw.cond)
      JC_ALWAYS:     take = 1'b1;
      JC_NOT_FINISH: take = !finish_c;
      JC_DIV_MORE:   take = (div_cnt_r != 5'd0);
      JC_TARE:       take = tare_r;
      default:       take = 1'b0;
    endcase
    if (!go) begin
      step_nxt = step_r;
    end else if (take) begin
      step_nxt = ucw.target;
    end else begin
      step_nxt = step_r + 4'd1;
    end
  end

  // serial bus logic for one beat
  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    smp_cnt_nxt = smp_cnt_r;
    shift_nxt   = shift_r;
    sum_nxt     = sum_r;
    tare_nxt    = tare_r;
    pdown_nxt   = pdown_r;
    sck_c       = 1'b0;
    finish_c    = 1'b0;
    handled_c   = 1'b0;
    sum_add_c   = sum_r + 32'(shift_r ^ TOP_BIT);
    smp_inc_c   = smp_cnt_r + 8'd1;
    limit_c     = (sample_count_r == 8'd0) ? 8'd1 : sample_count_r;
    div_n_c     = (smp_inc_c == 8'd0) ? 9'd256 : {1'b0, smp_inc_c};

    // requests
    if (in_data.req_type == REQ_PDOWN) begin
      pdown_nxt   = 1'b1;
      phase_nxt   = PH_IDLE;
      bit_cnt_nxt = '0;
      smp_cnt_nxt = '0;
      shift_nxt   = '0;
      sum_nxt     = '0;
      sck_c       = 1'b1;
      handled_c   = 1'b1;
    end else if (in_data.req_type == REQ_PUP && pdown_r) begin
      pdown_nxt = 1'b0;
      handled_c = 1'b1;
    end else if ((in_data.req_type == REQ_MEASURE || in_data.req_type == REQ_TARE) &&
                 phase_r == PH_IDLE && !pdown_r) begin
      tare_nxt    = (in_data.req_type == REQ_TARE);
      bit_cnt_nxt = '0;
      smp_cnt_nxt = '0;
      shift_nxt   = '0;
      sum_nxt     = '0;
      phase_nxt   = PH_WAIT;
      handled_c   = 1'b1;
    end

    // tick handling per phase
    if (!handled_c) begin
      case (phase_r)
        PH_WAIT: begin
          if (!in_data.dout_level) begin
            bit_cnt_nxt = '0;
            shift_nxt   = '0;
            phase_nxt   = PH_HIGH;
            sck_c       = 1'b1;
          end
        end
        PH_HIGH: begin
          phase_nxt = PH_SAMPLE;
        end
        PH_SAMPLE: begin
          shift_nxt   = {shift_r[DATA_BITS-2:0], in_data.dout_level};
          bit_cnt_nxt = bit_cnt_r + 5'd1;
          phase_nxt   = (bit_cnt_nxt < DATA_BITS_C) ? PH_HIGH : PH_EXTRA;
          sck_c       = 1'b1;
        end
        PH_EXTRA: begin
          sum_nxt     = sum_add_c;
          smp_cnt_nxt = smp_inc_c;
          bit_cnt_nxt = '0;
          shift_nxt   = '0;
          if (smp_inc_c != 8'd0 && smp_inc_c < limit_c) begin
            phase_nxt = PH_WAIT;
          end else begin
            finish_c    = 1'b1;
            phase_nxt   = PH_IDLE;
            smp_cnt_nxt = '0;
            sum_nxt     = '0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          sck_c     = pdown_r;
        end
      endcase
    end
  end

  // one restoring divide step
  always_comb begin
    rem_sh_c  = {div_rem_r, div_q_r[31]};
    q_bit_c   = (rem_sh_c >= {1'b0, div_d_r});
    rem_nxt_c = q_bit_c ? 9'(rem_sh_c - {1'b0, div_d_r}) : rem_sh_c[8:0];
  end

  // weight arithmetic helpers
  always_comb begin
    diff_c  = {1'b0, res_avg_r} - {1'b0, offset_r};
    q_c     = prod_r[55:24];
    q_sat_c = (q_c > {8'd0, NEG_FLOOR}) ? NEG_FLOOR : q_c[23:0];
  end

  // control state, configuration and bus state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r         <= STEP_ACCEPT;
      sample_count_r <= SAMPLE_COUNT_RST;
      gain_r         <= GAIN_Q32_RST;
      clamp_r        <= CLAMP_Q8_RST;
      phase_r        <= PH_IDLE;
      bit_cnt_r      <= '0;
      smp_cnt_r      <= '0;
      shift_r        <= '0;
      sum_r          <= '0;
      offset_r       <= OFFSET_RST;
      tare_r         <= 1'b0;
      pdown_r        <= 1'b0;
      div_cnt_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      step_r <= step_nxt;

      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_COUNT: sample_count_r <= cfg_wdata[7:0];
          CFG_GAIN_Q32:     gain_r         <= cfg_wdata;
          CFG_CLAMP_Q8:     clamp_r        <= cfg_wdata[22:0];
          default: ;
        endcase
      end

      // bus state commits on the input beat
      if (in_beat) begin
        phase_r   <= phase_nxt;
        bit_cnt_r <= bit_cnt_nxt;
        smp_cnt_r <= smp_cnt_nxt;
        shift_r   <= shift_nxt;
        sum_r     <= sum_nxt;
        tare_r    <= tare_nxt;
        pdown_r   <= pdown_nxt;
      end

      // divide loop counter
      if (in_beat && finish_c) begin
        div_cnt_r <= 5'd31;
      end else if (ucw.op == OP_DIV) begin
        div_cnt_r <= div_cnt_r - 5'd1;
      end

      // new offset on a tare result
      if (ucw.op == OP_AVG && tare_r) begin
        offset_r <= div_q_r[23:0];
      end

      // output register
      if (ucw.op == OP_EMIT && emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (ucw.op)
      OP_ACCEPT: begin
        if (in_valid) begin
          res_sck_r    <= sck_c;
          res_busy_r   <= (phase_nxt != PH_IDLE);
          res_mdone_r  <= 1'b0;
          res_tdone_r  <= 1'b0;
          res_avg_r    <= '0;
          res_weight_r <= '0;
          div_q_r      <= sum_add_c;
          div_rem_r    <= '0;
          div_d_r      <= div_n_c;
        end
      end
      OP_DIV: begin
        div_q_r   <= {div_q_r[30:0], q_bit_c};
        div_rem_r <= rem_nxt_c;
      end
      OP_AVG: begin
        res_avg_r   <= div_q_r[23:0];
        res_tdone_r <= tare_r;
        res_mdone_r <= !tare_r;
      end
      OP_DIFF: begin
        neg_r <= diff_c[24];
        mag_r <= diff_c[24] ? 24'(-diff_c) : diff_c[23:0];
      end
      OP_MUL_LO: begin
        pp_lo_r <= 40'(mag_r) * 40'(gain_r[15:0]);
      end
      OP_MUL_HI: begin
        pp_hi_r <= 40'(mag_r) * 40'(gain_r[31:16]);
      end
      OP_SUM: begin
        prod_r <= 56'(pp_lo_r) + {pp_hi_r, 16'd0} + ROUND_HALF;
      end
      OP_SCALE: begin
        if (!neg_r) begin
          res_weight_r <= (q_c > {9'd0, clamp_r}) ? 24'd0 : q_c[23:0];
        end else begin
          res_weight_r <= 24'(-q_sat_c);
        end
      end
      OP_EMIT: begin
        if (emit_ok) begin
          out_data_r.sck_level    <= res_sck_r;
          out_data_r.busy_res     <= res_busy_r;
          out_data_r.measure_done <= res_mdone_r;
          out_data_r.tare_done    <= res_tdone_r;
          out_data_r.raw_average  <= res_avg_r;
          out_data_r.weight_q8    <= res_weight_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `LCAR_ASSERT_NEXT(a_finish_starts_div, in_beat && finish_c, step_r == STEP_DIV)
  `LCAR_ASSERT_NEXT(a_div_ends_in_avg, step_r == STEP_DIV && div_cnt_r == 5'd0, step_r == STEP_AVG)
  `LCAR_ASSERT_NOW(a_result_from_emit, out_valid_r && !$past(out_valid_r), $past(step_r) == STEP_EMIT)
  `LCAR_ASSERT_NOW(a_single_done, out_valid_r, !(out_data_r.measure_done && out_data_r.tare_done))
  `LCAR_ASSERT_NOW(a_weight_only_on_measure, out_valid_r && !out_data_r.measure_done, out_data_r.weight_q8 == 24'sd0)

endmodule
